// ----- src/tcf_pkg.sv -----
`timescale 1ns / 1ps

package tcf_pkg;

    // item and register widths
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int TS_W    = 16;
    localparam int WGT_W   = 17;
    localparam int R2D_W   = 23;
    localparam int FACT_W  = 24;
    localparam int ADDR_W  = 4;

    // divider runs one quotient bit per cycle over the widened numerator
    localparam int DIV_STEPS = DATA_W + FRAC_W;
    localparam int MUL_STEPS = 8;

    // register reset values
    localparam logic [TS_W-1:0]  TIMESTEP_RST  = TS_W'(65);
    localparam logic [WGT_W-1:0] GYRO_WGT_RST  = WGT_W'(65470);
    localparam logic [WGT_W-1:0] ACCEL_WGT_RST = WGT_W'(65);
    localparam logic [R2D_W-1:0] RAD2DEG_RST   = R2D_W'(3754936);

    // register indexes
    localparam logic [1:0] REG_TIMESTEP  = 2'd0;
    localparam logic [1:0] REG_GYRO_WGT  = 2'd1;
    localparam logic [1:0] REG_ACCEL_WGT = 2'd2;
    localparam logic [1:0] REG_RAD2DEG   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    // magnitude of a signed word, most negative value maps to 2^31
    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        mag32 = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

endpackage

// ----- src/tilt_complementary_filter.sv -----
`timescale 1ns / 1ps

// an accepted item passes through two serial divides of 48 quotient bits
// each, eight passes of the shared multiplier and a handoff state;
// a zero accel_z skips the divider
// no new item is taken until the result is handed off, so the bit-serial
// divider sets the rate; a stalled result holds off the next item
// reset: asynchronous active low, angles cleared, registers to their defaults
module tilt_complementary_filter
    import tcf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // accel_x, accel_y, accel_z, rate_x, rate_y (32 bits each, low first)
    input  logic [5*DATA_W-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // tilt_x, tilt_y (32 bits each, low first)
    output logic [2*DATA_W-1:0] m_tdata,
    // divide_fault
    output logic                m_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    state_t state_reg, state_next;

    logic [TS_W-1:0]   timestep_reg;
    logic [WGT_W-1:0]  gyro_wgt_reg;
    logic [WGT_W-1:0]  accel_wgt_reg;
    logic [R2D_W-1:0]  rad2deg_reg;

    logic [DATA_W-1:0] angle_x_reg, angle_y_reg;
    logic [DATA_W-1:0] tilt_x_reg, tilt_y_reg;
    logic              fault_out_reg;
    logic              out_valid_reg;

    logic [5:0]        div_cnt_reg;
    logic              div_second_reg;
    logic [2:0]        mul_step_reg;

    logic [DATA_W-1:0] accel_x_reg, rate_x_reg, rate_y_reg;
    logic              az_neg_reg;
    logic              fault_reg;
    logic              quo_neg_reg;
    logic [DATA_W-1:0] den_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DIV_STEPS-1:0] dq_reg;
    logic [DATA_W-1:0] t0_reg, t1_reg, ex_reg, ey_reg;

    logic [DATA_W-1:0] in_ax, in_ay, in_az, in_rx, in_ry;
    logic              in_fire, out_load, cfg_wr;

    logic [DATA_W:0]   div_trial, div_diff;
    logic              div_fits;
    logic [DATA_W-1:0] rem_step;
    logic [DIV_STEPS-1:0] dq_step;
    logic [DATA_W-1:0] div_res;
    logic              div_last;

    logic [DATA_W-1:0] mul_a;
    logic [FACT_W-1:0] mul_b;
    logic signed [DATA_W+FACT_W:0] mul_full;
    logic [DATA_W-1:0] mul_res;

    logic [DATA_W-1:0] tilt_x_new, tilt_y_new;

    // input fields
    assign in_ax = s_tdata[DATA_W-1:0];
    assign in_ay = s_tdata[2*DATA_W-1:DATA_W];
    assign in_az = s_tdata[3*DATA_W-1:2*DATA_W];
    assign in_rx = s_tdata[4*DATA_W-1:3*DATA_W];
    assign in_ry = s_tdata[5*DATA_W-1:4*DATA_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    assign m_tdata  = {tilt_y_reg, tilt_x_reg};
    assign m_tuser  = fault_out_reg;
    assign m_tvalid = out_valid_reg;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_TIMESTEP:  prdata = 32'(timestep_reg);
            REG_GYRO_WGT:  prdata = 32'(gyro_wgt_reg);
            REG_ACCEL_WGT: prdata = 32'(accel_wgt_reg);
            REG_RAD2DEG:   prdata = 32'(rad2deg_reg);
            default:       prdata = '0;
        endcase
    end

    // restoring divide step, one quotient bit
    assign div_trial = {rem_reg, dq_reg[DIV_STEPS-1]};
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign div_fits  = !div_diff[DATA_W];
    assign rem_step  = div_fits ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
    assign dq_step   = {dq_reg[DIV_STEPS-2:0], div_fits};
    assign div_res   = quo_neg_reg ? (~dq_step[DATA_W-1:0] + DATA_W'(1))
                                   : dq_step[DATA_W-1:0];
    assign div_last  = (div_cnt_reg == 6'(DIV_STEPS - 1));

    // shared multiplier operand select
    always_comb
    begin
        case (mul_step_reg)
            3'd0:    mul_a = rate_x_reg;
            3'd1:    mul_a = rate_y_reg;
            3'd2:    mul_a = ex_reg;
            3'd3:    mul_a = ey_reg;
            3'd4:    mul_a = t0_reg;
            3'd5:    mul_a = t1_reg;
            3'd6:    mul_a = ex_reg;
            3'd7:    mul_a = ey_reg;
            default: mul_a = '0;
        endcase
        case (mul_step_reg[2:1])
            2'd0:    mul_b = FACT_W'(timestep_reg);
            2'd1:    mul_b = FACT_W'(rad2deg_reg);
            2'd2:    mul_b = FACT_W'(gyro_wgt_reg);
            2'd3:    mul_b = FACT_W'(accel_wgt_reg);
            default: mul_b = '0;
        endcase
    end

    // signed value times unsigned factor, floor shift, wrap to 32 bits
    assign mul_full = $signed(mul_a) * $signed({1'b0, mul_b});
    assign mul_res  = mul_full[DATA_W+FRAC_W-1:FRAC_W];

    assign tilt_x_new = t0_reg - ex_reg;
    assign tilt_y_new = t1_reg - ey_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = (in_az == '0) ? ST_MUL : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_last && div_second_reg)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_step_reg == 3'(MUL_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control, config and kept angles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            timestep_reg   <= TIMESTEP_RST;
            gyro_wgt_reg   <= GYRO_WGT_RST;
            accel_wgt_reg  <= ACCEL_WGT_RST;
            rad2deg_reg    <= RAD2DEG_RST;
            angle_x_reg    <= '0;
            angle_y_reg    <= '0;
            out_valid_reg  <= 1'b0;
            div_cnt_reg    <= '0;
            div_second_reg <= 1'b0;
            mul_step_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_TIMESTEP:  timestep_reg  <= pwdata[TS_W-1:0];
                    REG_GYRO_WGT:  gyro_wgt_reg  <= pwdata[WGT_W-1:0];
                    REG_ACCEL_WGT: accel_wgt_reg <= pwdata[WGT_W-1:0];
                    REG_RAD2DEG:   rad2deg_reg   <= pwdata[R2D_W-1:0];
                    default:       ;
                endcase
            end

            // divider step count, two divides back to back
            if (in_fire)
            begin
                div_cnt_reg    <= '0;
                div_second_reg <= 1'b0;
            end
            else if (state_reg == ST_DIV)
            begin
                if (div_last)
                begin
                    div_cnt_reg    <= '0;
                    div_second_reg <= 1'b1;
                end
                else
                    div_cnt_reg <= div_cnt_reg + 6'd1;
            end

            // multiplier pass count
            if (in_fire)
                mul_step_reg <= '0;
            else if (state_reg == ST_MUL)
                mul_step_reg <= mul_step_reg + 3'd1;

            // result handoff and angle update
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                angle_x_reg   <= tilt_x_new;
                angle_y_reg   <= tilt_y_new;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            accel_x_reg <= in_ax;
            rate_x_reg  <= in_rx;
            rate_y_reg  <= in_ry;
            az_neg_reg  <= in_az[DATA_W-1];
            fault_reg   <= (in_az == '0);
            den_reg     <= mag32(in_az);
            rem_reg     <= '0;
            dq_reg      <= {mag32(in_ay), FRAC_W'(0)};
            quo_neg_reg <= in_ay[DATA_W-1] ^ in_az[DATA_W-1];
            // accel angles held at zero when accel_z is zero
            ex_reg      <= '0;
            ey_reg      <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            if (div_last)
            begin
                if (!div_second_reg)
                begin
                    ex_reg      <= div_res;
                    rem_reg     <= '0;
                    dq_reg      <= {mag32(accel_x_reg), FRAC_W'(0)};
                    quo_neg_reg <= accel_x_reg[DATA_W-1] ^ az_neg_reg;
                end
                else
                    ey_reg <= div_res;
            end
            else
            begin
                rem_reg <= rem_step;
                dq_reg  <= dq_step;
            end
        end
        else if (state_reg == ST_MUL)
        begin
            case (mul_step_reg)
                3'd0: t0_reg <= mul_res;
                3'd1: t1_reg <= mul_res;
                3'd2:
                begin
                    ex_reg <= mul_res;
                    t0_reg <= angle_x_reg - t0_reg;
                end
                3'd3:
                begin
                    ey_reg <= mul_res;
                    t1_reg <= angle_y_reg + t1_reg;
                end
                3'd4: t0_reg <= mul_res;
                3'd5: t1_reg <= mul_res;
                3'd6: ex_reg <= mul_res;
                3'd7: ey_reg <= mul_res;
                default: ;
            endcase
        end

        // output register
        if (out_load)
        begin
            tilt_x_reg    <= tilt_x_new;
            tilt_y_reg    <= tilt_y_new;
            fault_out_reg <= fault_reg;
        end
    end

endmodule
